FILE: hdl/adc_gar_pkg.sv
// ----------------------------------------------------------------------------
// adc_gar_pkg - shared types and constants for the gain auto-ranging block
// Word layouts, gain table and reset values used by the interfaces and RTL.
// ----------------------------------------------------------------------------
package adc_gar_pkg;

	localparam int unsigned STEPS     = 2;
	localparam int unsigned STEP_W    = 1;
	localparam int unsigned SLOTS     = 2 * STEPS;
	localparam int unsigned SLOT_W    = $clog2(SLOTS);
	localparam int unsigned SAMPLE_W  = 24;
	localparam int unsigned LEVELS    = 8;
	localparam int unsigned LEVEL_W   = 3;
	localparam int unsigned CODE_W    = 3;
	localparam int unsigned RAISE_MAX = LEVELS - 1;

	// 90 percent of full scale
	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 24'hE66666;
	// gain 32 after reset
	localparam logic [LEVEL_W-1:0]  RESET_LEVEL     = 3'd5;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic               kind;
		logic [STEP_W-1:0]  step_index;
		sample_t            raw_sample;
	} in_word_t;

	typedef struct packed {
		code_t  gain_code;
		level_t gain_level;
		logic   overrange;
		logic   range_warning;
	} out_word_t;

	// amplifier select code for each gain level (gain 1 .. 128)
	function automatic code_t level_to_code(input level_t lvl);
		code_t c;
		case (lvl)
			3'd0:    c = 3'd5;
			3'd1:    c = 3'd7;
			3'd2:    c = 3'd4;
			3'd3:    c = 3'd6;
			3'd4:    c = 3'd1;
			3'd5:    c = 3'd3;
			3'd6:    c = 3'd0;
			default: c = 3'd2;
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/adc_gar_if.sv
// ----------------------------------------------------------------------------
// adc_gar_if - valid/ready channels for the gain auto-ranging block
// One interface for sample words, one for result words.
// ----------------------------------------------------------------------------
interface adc_gar_in_if;
	logic                  valid;
	logic                  ready;
	adc_gar_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface adc_gar_out_if;
	logic                   valid;
	logic                   ready;
	adc_gar_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/adc_gain_auto_ranging.sv
// ----------------------------------------------------------------------------
// adc_gain_auto_ranging - amplifier gain auto-ranging for two converter channels
// Tracks one gain level per channel and step and adjusts it from raw samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample : sink channel; each word carries kind (measure/reference),
//            step_index and a 24-bit raw_sample taken at the current gain.
//   result : source channel; one word per sample with the new gain_code,
//            gain_level, overrange and range_warning.
//   thr_we / thr_wdata : write the overrange threshold; change it only while
//            no word is in flight.
// Timing:
//   A sample word is registered in the input stage, then the decision is made in
//   combinational logic (seven shifted compares against the threshold and a table
//   lookup) and lands in the result register. One word is taken every cycle
//   while the result is not stalled; the gain store is written at the same edge
//   the result register loads, so consecutive words to the same slot see the
//   updated level without extra forwarding.
// Reset:
//   arst_n clears both stages, sets every slot to level 5 (gain 32, code 3)
//   and loads the threshold with 0xE66666.
// Stall:
//   While result.ready is low the result word holds; the input stage keeps
//   one more word, after which sample.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module adc_gain_auto_ranging (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         thr_we,
	input  adc_gar_pkg::sample_t         thr_wdata,
	adc_gar_in_if.sink                   sample,
	adc_gar_out_if.source                result
);

	// threshold register
	adc_gar_pkg::sample_t thr_q;

	// input stage
	logic                  s1_valid_q;
	adc_gar_pkg::in_word_t s1_word_q;

	// result stage
	logic                   out_valid_q;
	adc_gar_pkg::out_word_t out_word_q;

	// gain level per slot (slot = kind * STEPS + step)
	adc_gar_pkg::level_t level_q [adc_gar_pkg::SLOTS];

	logic                                s1_adv;
	logic [adc_gar_pkg::SLOT_W-1:0]      s1_slot;
	adc_gar_pkg::level_t                 cur_level;
	logic                                over;
	logic [adc_gar_pkg::RAISE_MAX-1:0]   fits;
	logic [adc_gar_pkg::LEVEL_W-1:0]     fit_count;
	logic [adc_gar_pkg::LEVEL_W-1:0]     headroom;
	logic [adc_gar_pkg::LEVEL_W-1:0]     raise;
	adc_gar_pkg::level_t                 new_level;
	adc_gar_pkg::out_word_t              new_word;

	// Advance the input stage when the result register is free or being taken
	assign s1_adv       = s1_valid_q && (!out_valid_q || result.ready);
	assign sample.ready = !s1_valid_q || s1_adv;

	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= adc_gar_pkg::THRESHOLD_RESET;
		end else if (thr_we) begin
			thr_q <= thr_wdata;
		end
	end

	// Input register: hold the word until the result stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (sample.ready) begin
			s1_valid_q <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			s1_word_q <= sample.data;
		end
	end

	// Slot select; out-of-range steps wrap (STEPS is a power of two here)
	assign s1_slot = adc_gar_pkg::SLOT_W'(s1_word_q.kind) * adc_gar_pkg::SLOT_W'(adc_gar_pkg::STEPS)
		+ adc_gar_pkg::SLOT_W'(s1_word_q.step_index % adc_gar_pkg::STEPS);
	assign cur_level = level_q[s1_slot];

	assign over = s1_word_q.raw_sample > thr_q;

	// Test every possible rise in parallel; the shifted sample only grows,
	// so the passing tests form a run from one upwards and their count is
	// the largest rise that stays under the threshold.
	always_comb begin
		for (int k = 1; k <= adc_gar_pkg::RAISE_MAX; k++) begin
			fits[k-1] = ({{adc_gar_pkg::RAISE_MAX{1'b0}}, s1_word_q.raw_sample} << k)
				< {{adc_gar_pkg::RAISE_MAX{1'b0}}, thr_q};
		end
	end

	assign fit_count = adc_gar_pkg::LEVEL_W'($countones(fits));
	assign headroom  = adc_gar_pkg::LEVEL_W'(adc_gar_pkg::RAISE_MAX) - cur_level;
	assign raise     = (fit_count < headroom) ? fit_count : headroom;

	always_comb begin
		if (over) begin
			// drop one level, hold at gain 1
			new_level = (cur_level != '0) ? cur_level - 1'b1 : cur_level;
		end else begin
			new_level = cur_level + raise;
		end
		new_word.gain_code     = adc_gar_pkg::level_to_code(new_level);
		new_word.gain_level    = new_level;
		new_word.overrange     = over;
		new_word.range_warning = over || (raise != '0);
	end

	// Result register and gain store advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < adc_gar_pkg::SLOTS; i++) begin
				level_q[i] <= adc_gar_pkg::RESET_LEVEL;
			end
		end else begin
			if (s1_adv) begin
				out_valid_q      <= 1'b1;
				level_q[s1_slot] <= new_level;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_word_q <= new_word;
		end
	end

	// ------------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------------
	a_warn_covers_over: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!result.data.overrange || result.data.range_warning))
		else $error("overrange without range_warning");

	a_code_matches_level: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			(result.data.gain_code == adc_gar_pkg::level_to_code(result.data.gain_level)))
		else $error("gain_code does not match gain_level");

	a_no_input_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |-> (!s1_valid_q || s1_adv))
		else $error("sample word accepted over a held input word");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_word_q)))
		else $error("input stage lost its word during a stall");

endmodule
